// File: design/mma_pkg.sv
// Shared types, constants and the status length decode for the MIDI message assembler.
`default_nettype none

package mma_pkg;

  // Widths of the byte stream, the packed message and the remaining-byte count.
  localparam int unsigned ByteW = 8;
  localparam int unsigned WordW = 32;
  localparam int unsigned LenW  = 2;

  // Message lengths; zero marks a byte that starts nothing.
  localparam logic [LenW-1:0] LEN_NONE  = 2'd0;
  localparam logic [LenW-1:0] LEN_ONE   = 2'd1;
  localparam logic [LenW-1:0] LEN_TWO   = 2'd2;
  localparam logic [LenW-1:0] LEN_THREE = 2'd3;

  // Status byte codes that need their own decode.
  localparam logic [ByteW-1:0] ST_SYSEX_START = 8'hF0;
  localparam logic [ByteW-1:0] ST_TIME_CODE   = 8'hF1;
  localparam logic [ByteW-1:0] ST_SONG_POS    = 8'hF2;
  localparam logic [ByteW-1:0] ST_SONG_SEL    = 8'hF3;
  localparam logic [ByteW-1:0] ST_UNDEF_F4    = 8'hF4;
  localparam logic [ByteW-1:0] ST_UNDEF_F5    = 8'hF5;
  localparam logic [ByteW-1:0] ST_SYSEX_END   = 8'hF7;
  localparam logic [ByteW-1:0] ST_UNDEF_F9    = 8'hF9;
  localparam logic [ByteW-1:0] ST_UNDEF_FD    = 8'hFD;

  // High nibbles of the channel message groups.
  localparam logic [3:0] GRP_NOTE_OFF  = 4'h8;
  localparam logic [3:0] GRP_NOTE_ON   = 4'h9;
  localparam logic [3:0] GRP_POLY_AT   = 4'hA;
  localparam logic [3:0] GRP_CTRL      = 4'hB;
  localparam logic [3:0] GRP_PROGRAM   = 4'hC;
  localparam logic [3:0] GRP_CHAN_AT   = 4'hD;
  localparam logic [3:0] GRP_PITCH    = 4'hE;

  // Result of one accepted byte, handed from the assembler to the output stage.
  typedef struct packed {
    logic             valid;
    logic [WordW-1:0] word;
  } emit_t;

  // Message length of a byte seen while no message is open.
  function automatic logic [LenW-1:0] status_length(input logic [ByteW-1:0] b);
    logic [LenW-1:0] len;
    len = LEN_NONE;
    if (b[7]) begin
      unique case (b[7:4])
        GRP_NOTE_OFF, GRP_NOTE_ON, GRP_POLY_AT, GRP_CTRL, GRP_PITCH: len = LEN_THREE;
        GRP_PROGRAM, GRP_CHAN_AT: len = LEN_TWO;
        default: begin
          unique case (b) inside
            ST_SYSEX_START, ST_SYSEX_END, ST_UNDEF_F4, ST_UNDEF_F5,
            ST_UNDEF_F9, ST_UNDEF_FD: len = LEN_NONE;
            ST_TIME_CODE, ST_SONG_SEL: len = LEN_TWO;
            ST_SONG_POS: len = LEN_THREE;
            default: len = LEN_ONE;
          endcase
        end
      endcase
    end
    return len;
  endfunction

endpackage

`default_nettype wire

// File: design/mma_core.sv
// Message state of the MIDI assembler: opens, fills and completes one message word.
`default_nettype none

module mma_core (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          accept,
  input  wire logic [mma_pkg::ByteW-1:0]     data_byte,
  input  wire logic [mma_pkg::ByteW-1:0]     port_number,
  output mma_pkg::emit_t                     emit
);

  logic [mma_pkg::LenW-1:0]  remain_r, remain_nxt;
  logic                      first_r, first_nxt;
  logic [mma_pkg::WordW-1:0] word_r, word_nxt;
  logic [mma_pkg::LenW-1:0]  len;

  // Next message state and the completed word, if this byte closes one.
  always_comb begin
    remain_nxt = remain_r;
    first_nxt  = first_r;
    word_nxt   = word_r;
    emit.valid = 1'b0;
    len        = mma_pkg::status_length(data_byte);
    if (accept) begin
      if (remain_r == mma_pkg::LEN_NONE) begin
        if (len != mma_pkg::LEN_NONE) begin
          // A new status byte latches the port with cleared data bytes.
          word_nxt = {data_byte, 16'h0000, port_number};
          if (len == mma_pkg::LEN_ONE) begin
            emit.valid = 1'b1;
          end else begin
            remain_nxt = len - mma_pkg::LEN_ONE;
            first_nxt  = 1'b1;
          end
        end
      end else begin
        // The first data byte of a message goes to bits 23:16, the second to 15:8.
        if (first_r) begin
          word_nxt[23:16] = data_byte;
        end else begin
          word_nxt[15:8] = data_byte;
        end
        first_nxt  = 1'b0;
        remain_nxt = remain_r - mma_pkg::LEN_ONE;
        if (remain_r == mma_pkg::LEN_ONE) begin
          emit.valid = 1'b1;
        end
      end
    end
    emit.word = word_nxt;
  end

  // Remaining count and data byte position are control state; the word is payload.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      remain_r <= mma_pkg::LEN_NONE;
      first_r  <= 1'b0;
    end else begin
      remain_r <= remain_nxt;
      first_r  <= first_nxt;
    end
  end

  always_ff @(posedge clk) begin
    word_r <= word_nxt;
  end

endmodule

`default_nettype wire

// File: design/midi_message_assembler.sv
// Top level of the MIDI message assembler: stream ports, port register and output register.
//
//  Channel  Direction  Handshake             Payload
//  in_      slave      in_tvalid/in_tready   in_tdata[7:0]   = data_byte
//  out_     master     out_tvalid/out_tready out_tdata[31:0] = message_word
//  cfg_     slave      cfg_valid/cfg_ready   cfg_data[7:0]   = port_number
//
// One byte is taken every cycle; a completed message appears in the output
// register on the cycle after its last byte. The only limit is the single
// output register: a new byte waits only while a word sits there unclaimed.
// Reset (rst_n low, synchronous) clears the port register to zero, closes any
// open message and empties the output register. cfg_ready is always high.
`default_nettype none

module midi_message_assembler (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  // Input word: [7:0] data_byte
  input  wire logic                       in_tvalid,
  output logic                            in_tready,
  input  wire logic [mma_pkg::ByteW-1:0]  in_tdata,
  // Output word: [31:0] message_word
  output logic                            out_tvalid,
  input  wire logic                       out_tready,
  output logic [mma_pkg::WordW-1:0]       out_tdata,
  // Configuration word: [7:0] port_number
  input  wire logic                       cfg_valid,
  output logic                            cfg_ready,
  input  wire logic [mma_pkg::ByteW-1:0]  cfg_data
);

  logic [mma_pkg::ByteW-1:0] port_r;
  logic                      out_valid_r;
  logic [mma_pkg::WordW-1:0] out_data_r;
  logic                      in_accept;
  mma_pkg::emit_t            emit;

  // Accept while the output register is empty or draining this cycle.
  assign in_tready = !out_valid_r || out_tready;
  assign in_accept = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;

  // Port number register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      port_r <= '0;
    end else if (cfg_valid) begin
      port_r <= cfg_data;
    end
  end

  mma_core u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .accept      (in_accept),
    .data_byte   (in_tdata),
    .port_number (port_r),
    .emit        (emit)
  );

  // Output register: load a finished word, drop it once taken.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit.valid) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit.valid) begin
      out_data_r <= emit.word;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

`default_nettype wire

// File: design/mma_checker.sv
// Port-level checks for the MIDI message assembler, bound to its top level.
`default_nettype none

module mma_checker (
  input wire logic                       clk,
  input wire logic                       rst_n,
  input wire logic                       in_tvalid,
  input wire logic                       in_tready,
  input wire logic                       out_tvalid,
  input wire logic                       out_tready,
  input wire logic [mma_pkg::WordW-1:0]  out_tdata
);

  // A word waiting at the output holds its data.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("output word changed while stalled");

  // Every emitted word carries a status byte.
  a_status_bit: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[31])
    else $error("emitted word without a status byte");

  // An empty output register never blocks input.
  a_ready_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input stalled with empty output");

  // A new word appears only after an accepted byte.
  a_word_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(in_tvalid && in_tready))
    else $error("word emitted without an input byte");

  // Reset empties the output.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("output valid after reset");

endmodule

bind midi_message_assembler mma_checker u_mma_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

`default_nettype wire
